### rtl/bounded_deque_with_dump_assert.svh
// ----------------------------------------------------------------------------
// bounded_deque_with_dump_assert.svh
// Assertion macros for the deque controller; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_DUMP_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_DUMP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define BDQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled in reset
`define BDQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BDQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define BDQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

### rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Opcodes, status codes, cell actions and controller states of the deque.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;

    // request opcodes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_LIST       = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4
    } op_t;

    // result status
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // per-cycle command broadcast to every cell
    typedef enum logic [2:0] {
        ACT_HOLD,
        ACT_PUSH_FRONT,
        ACT_PUSH_BACK,
        ACT_POP_FRONT,
        ACT_POP_BACK,
        ACT_ROTATE
    } act_t;

    // controller states
    typedef enum logic {
        ST_ACCEPT,
        ST_LIST
    } state_t;

endpackage

`default_nettype wire

### rtl/bounded_deque_with_dump.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_dump
// Double-ended queue of DEPTH entries built as a chain of cells, with
// push/pop at both ends and a front-to-back dump of all entries.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_op, s_value
//   m_       out  m_valid/m_ready    m_status, m_data, m_fill, m_last
//
// Push, pop and unused opcodes: one result beat per request.
// List: N beats for N held entries (one beat if empty), one per cycle
// while the output is free; the cell chain rotates its held prefix once
// per beat, so requests are held off until the last beat has been loaded.
// Reset (synchronous, aresetn low) clears fill count and control only;
// entries are not cleared and need no sweep.
// A stalled result beat holds the request side; one result register
// separates the two sides.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_dump
    import bdq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic        [OP_W-1:0]       s_op,
    input  wire logic signed [VALUE_W-1:0]    s_value,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic             [STATUS_W-1:0]   m_status,
    output logic signed      [VALUE_W-1:0]    m_data,
    output logic             [$clog2(DEPTH+1)-1:0] m_fill,
    output logic                              m_last
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    act_t                  cell_act;
    logic [CNT_W-1:0]      cell_cnt;
    logic [DATA_WIDTH-1:0] wr_value;
    logic [DATA_WIDTH-1:0] a_q      [DEPTH];
    logic [DATA_WIDTH-1:0] b_q      [DEPTH];
    logic [DATA_WIDTH-1:0] a_left_w [DEPTH];
    logic [DATA_WIDTH-1:0] a_right_w[DEPTH];
    logic [DATA_WIDTH-1:0] b_left_w [DEPTH];
    logic [DATA_WIDTH-1:0] b_right_w[DEPTH];
    logic [VALUE_W-1:0]    data_w;

    bdq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_op     (s_op),
        .s_value  (s_value),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .m_data   (data_w),
        .m_fill   (m_fill),
        .m_last   (m_last),
        .a_head   (a_q[0]),
        .b_tail   (b_q[DEPTH-1]),
        .cell_act (cell_act),
        .cell_cnt (cell_cnt),
        .wr_value (wr_value)
    );

    assign m_data = data_w;

    // chain of cells; the ends take the new value or keep their own
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign a_left_w[i] = wr_value;
            assign b_left_w[i] = b_q[i];
        end else begin : g_mid_l
            assign a_left_w[i] = a_q[i-1];
            assign b_left_w[i] = b_q[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign a_right_w[i] = a_q[i];
            assign b_right_w[i] = wr_value;
        end else begin : g_mid_r
            assign a_right_w[i] = a_q[i+1];
            assign b_right_w[i] = b_q[i+1];
        end

        bdq_cell #(
            .DEPTH      (DEPTH),
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (i)
        ) u_cell (
            .aclk     (aclk),
            .act      (cell_act),
            .count    (cell_cnt),
            .wr_value (wr_value),
            .a_left   (a_left_w[i]),
            .a_right  (a_right_w[i]),
            .a_head   (a_q[0]),
            .b_left   (b_left_w[i]),
            .b_right  (b_right_w[i]),
            .a_q      (a_q[i]),
            .b_q      (b_q[i])
        );
    end

endmodule

`default_nettype wire

### rtl/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell
// One slot of the deque chain. Holds a front-aligned copy (A) and a
// back-aligned copy (B) of one entry and trades them with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_cell
    import bdq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int INDEX      = 0
) (
    input  wire logic                  aclk,
    input  wire act_t                  act,
    input  wire logic [CNT_W-1:0]      count,
    input  wire logic [DATA_WIDTH-1:0] wr_value,
    input  wire logic [DATA_WIDTH-1:0] a_left,
    input  wire logic [DATA_WIDTH-1:0] a_right,
    input  wire logic [DATA_WIDTH-1:0] a_head,
    input  wire logic [DATA_WIDTH-1:0] b_left,
    input  wire logic [DATA_WIDTH-1:0] b_right,
    output logic      [DATA_WIDTH-1:0] a_q,
    output logic      [DATA_WIDTH-1:0] b_q
);

    // count values at which this cell is the slot being written
    localparam logic [CNT_W-1:0] A_SLOT = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] A_WRAP = CNT_W'(INDEX + 1);
    localparam logic [CNT_W-1:0] B_SLOT = CNT_W'(DEPTH - 1 - INDEX);

    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;

    // A: front entry lives in cell 0, entry k in cell k
    always_comb begin
        a_next = a_reg;
        case (act)
            ACT_PUSH_FRONT: a_next = a_left;
            ACT_PUSH_BACK:  if (count == A_SLOT) a_next = wr_value;
            ACT_POP_FRONT:  a_next = a_right;
            ACT_ROTATE: begin
                // rotate the held prefix by one; last held cell takes the head
                if (count == A_WRAP) begin
                    a_next = a_head;
                end else if (count > A_SLOT) begin
                    a_next = a_right;
                end
            end
            default: a_next = a_reg;
        endcase
    end

    // B: back entry lives in the last cell
    always_comb begin
        b_next = b_reg;
        case (act)
            ACT_PUSH_FRONT: if (count == B_SLOT) b_next = wr_value;
            ACT_PUSH_BACK:  b_next = b_right;
            ACT_POP_BACK:   b_next = b_left;
            default:        b_next = b_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign a_q = a_reg;
    assign b_q = b_reg;

endmodule

`default_nettype wire

### rtl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Request decode, fill count, list sequencing and the result register.
// Drives one command per cycle to the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_deque_with_dump_assert.svh"

module bdq_ctrl
    import bdq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // request channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [OP_W-1:0]       s_op,
    input  wire logic [VALUE_W-1:0]    s_value,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [STATUS_W-1:0]   m_status,
    output logic      [VALUE_W-1:0]    m_data,
    output logic      [CNT_W-1:0]      m_fill,
    output logic                       m_last,
    // cell chain
    input  wire logic [DATA_WIDTH-1:0] a_head,
    input  wire logic [DATA_WIDTH-1:0] b_tail,
    output act_t                       cell_act,
    output logic      [CNT_W-1:0]      cell_cnt,
    output logic      [DATA_WIDTH-1:0] wr_value
);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    logic [VALUE_W-1:0] out_data_reg;
    logic [CNT_W-1:0]   out_fill_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               load;
    status_t            res_status;
    logic [VALUE_W-1:0] res_data;
    logic [CNT_W-1:0]   res_fill;
    logic               res_last;
    logic               full;
    logic               empty;
    logic [63:0]        value_ext;
    logic [63:0]        head_ext;
    logic [63:0]        tail_ext;

    // width adaptation between the 32-bit ports and stored entries
    assign value_ext = 64'($unsigned(s_value));
    assign wr_value  = value_ext[DATA_WIDTH-1:0];
    assign head_ext  = 64'(a_head);
    assign tail_ext  = 64'(b_tail);

    assign full     = (cnt_reg == CNT_FULL);
    assign empty    = (cnt_reg == '0);
    assign out_free = !out_valid_reg || m_ready;
    assign cell_cnt = cnt_reg;

    // next state, cell command and result
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        cell_act   = ACT_HOLD;
        load       = 1'b0;
        res_status = STAT_OK;
        res_data   = '0;
        res_fill   = cnt_reg;
        res_last   = 1'b1;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_ACCEPT: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    load = 1'b1;
                    unique case (s_op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (full) begin
                                res_status = STAT_FULL;
                            end else begin
                                cell_act = (s_op == OP_PUSH_FRONT) ? ACT_PUSH_FRONT
                                                                   : ACT_PUSH_BACK;
                                cnt_next = cnt_reg + CNT_ONE;
                                res_fill = cnt_reg + CNT_ONE;
                            end
                        end
                        OP_LIST: begin
                            if (empty) begin
                                res_status = STAT_EMPTY;
                            end else begin
                                // first beat goes out now, the rest stream
                                cell_act = ACT_ROTATE;
                                res_data = head_ext[VALUE_W-1:0];
                                res_last = (cnt_reg == CNT_ONE);
                                rem_next = cnt_reg - CNT_ONE;
                                if (cnt_reg != CNT_ONE) begin
                                    state_next = ST_LIST;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (empty) begin
                                res_status = STAT_EMPTY;
                            end else if (s_op == OP_POP_FRONT) begin
                                cell_act = ACT_POP_FRONT;
                                res_data = head_ext[VALUE_W-1:0];
                                cnt_next = cnt_reg - CNT_ONE;
                                res_fill = cnt_reg - CNT_ONE;
                            end else begin
                                cell_act = ACT_POP_BACK;
                                res_data = tail_ext[VALUE_W-1:0];
                                cnt_next = cnt_reg - CNT_ONE;
                                res_fill = cnt_reg - CNT_ONE;
                            end
                        end
                        default: begin
                            // unused opcode: plain ok beat
                        end
                    endcase
                end
            end
            ST_LIST: begin
                if (out_free) begin
                    load     = 1'b1;
                    cell_act = ACT_ROTATE;
                    res_data = head_ext[VALUE_W-1:0];
                    res_last = (rem_reg == CNT_ONE);
                    rem_next = rem_reg - CNT_ONE;
                    if (rem_reg == CNT_ONE) begin
                        state_next = ST_ACCEPT;
                    end
                end
            end
            default: state_next = ST_ACCEPT;
        endcase
    end

    // result register valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACCEPT;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            out_status_reg <= res_status;
            out_data_reg   <= res_data;
            out_fill_reg   <= res_fill;
            out_last_reg   <= res_last;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_data   = out_data_reg;
    assign m_fill   = out_fill_reg;
    assign m_last   = out_last_reg;

    // checks
    `BDQ_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_FULL, "fill count above depth")
    `BDQ_ASSERT_IMP(a_list_blocks, aclk, aresetn, state_reg == ST_LIST, !s_ready, "request taken during list")
    `BDQ_ASSERT_NXT(a_list_cnt, aclk, aresetn, aresetn && state_reg == ST_LIST, $stable(cnt_reg), "fill count moved during list")
    `BDQ_ASSERT_NXT(a_pop_dec, aclk, aresetn, aresetn && s_valid && s_ready && !empty && (s_op == OP_POP_FRONT || s_op == OP_POP_BACK), cnt_reg == $past(cnt_reg) - CNT_ONE, "pop did not shrink queue")
    `BDQ_ASSERT_NXT(a_list_rem, aclk, aresetn, aresetn && state_reg == ST_LIST, rem_reg < cnt_reg, "list beats exceed fill")

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for bounded_deque_with_dump
// Runs a short table of corner cases first: empty pops and list, extreme
// values, an unused opcode and a full queue. Then 420 random requests
// follow, alternating between filling and draining phases. A shadow deque
// predicts untyped beats, and each beat is checked field by field.
// Both channels idle at random. One long output stall backs up the input,
// and once the input pauses until the queue of expected beats is empty.
// ----------------------------------------------------------------------------

module tb_top;
    import bdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int FILL_W       = $clog2(DEPTH + 1);
    localparam int RESET_CYCLES = 5;
    localparam int RAND_ITEMS   = 420;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 120;
    localparam int PAUSE_AT     = 260;
    localparam int DRAIN_CYCLES = 20;

    // opcodes the block does not decode
    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  data;
        logic [FILL_W-1:0]   fill;
        logic                last;
    } beat_t;

    // one row of corner cases; typed rows carry their own expected beat
    typedef struct {
        logic [OP_W-1:0]     op;
        logic [VALUE_W-1:0]  value;
        int                  reps;
        bit                  typed;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   fill;
    } corner_row_t;

    localparam int N_CORNER = 15;

    corner_row_t corner_tab [N_CORNER] = '{
        '{OP_POP_FRONT,  32'h0000_0000,  1, 1'b1, STAT_EMPTY, 5'd0},
        '{OP_POP_BACK,   32'h0000_0000,  1, 1'b1, STAT_EMPTY, 5'd0},
        '{OP_LIST,       32'h0000_0000,  1, 1'b1, STAT_EMPTY, 5'd0},
        '{OP_PUSH_BACK,  32'h7FFF_FFFF,  1, 1'b1, STAT_OK,    5'd1},
        '{OP_PUSH_FRONT, 32'h8000_0000,  1, 1'b1, STAT_OK,    5'd2},
        '{OP_PUSH_FRONT, 32'hFFFF_FFFF,  1, 1'b1, STAT_OK,    5'd3},
        '{OP_RSVD_5,     32'hDEAD_BEEF,  1, 1'b1, STAT_OK,    5'd3},
        '{OP_POP_BACK,   32'h0000_0000,  1, 1'b0, STAT_OK,    5'd0},
        '{OP_POP_FRONT,  32'h0000_0000,  1, 1'b0, STAT_OK,    5'd0},
        '{OP_PUSH_BACK,  32'hA5A5_0000, 15, 1'b0, STAT_OK,    5'd0},
        '{OP_PUSH_BACK,  32'h0000_0001,  1, 1'b1, STAT_FULL,  5'd16},
        '{OP_PUSH_FRONT, 32'h0000_0002,  1, 1'b1, STAT_FULL,  5'd16},
        '{OP_LIST,       32'h0000_0000,  1, 1'b0, STAT_OK,    5'd0},
        '{OP_POP_FRONT,  32'h0000_0000,  1, 1'b0, STAT_OK,    5'd0},
        '{OP_POP_BACK,   32'h0000_0000,  1, 1'b0, STAT_OK,    5'd0}
    };

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [OP_W-1:0]           s_op;
    logic signed [VALUE_W-1:0] s_value;
    logic                      m_valid;
    logic                      m_ready;
    logic [STATUS_W-1:0]       m_status;
    logic signed [VALUE_W-1:0] m_data;
    logic [FILL_W-1:0]         m_fill;
    logic                      m_last;

    logic [VALUE_W-1:0] shadow_q[$];   // deque contents, front first
    beat_t              exp_beats[$];  // beats still owed by the block
    beat_t              fresh_beats[$];
    int                 err_cnt = 0;
    int                 quiet_left = 0;
    bit                 long_hold_req = 1'b0;
    bit                 cur_typed;
    beat_t              cur_typed_beat;

    bounded_deque_with_dump #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_op     (s_op),
        .s_value  (s_value),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .m_data   (m_data),
        .m_fill   (m_fill),
        .m_last   (m_last)
    );

    // clock and reset
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns mismatch on %s: got %h, expected %h", $time, what, got, want);
        err_cnt++;
    endtask

    // apply one request to the shadow deque, return the beats it causes
    function automatic void deque_step(input logic [OP_W-1:0] op,
                                       input logic [VALUE_W-1:0] val,
                                       ref beat_t res[$]);
        logic [VALUE_W-1:0] popped;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (shadow_q.size() >= DEPTH) begin
                    res.push_back('{STAT_FULL, '0, FILL_W'(shadow_q.size()), 1'b1});
                end else begin
                    if (op == OP_PUSH_FRONT) shadow_q.push_front(val);
                    else shadow_q.push_back(val);
                    res.push_back('{STAT_OK, '0, FILL_W'(shadow_q.size()), 1'b1});
                end
            end
            OP_LIST: begin
                if (shadow_q.size() == 0) begin
                    res.push_back('{STAT_EMPTY, '0, '0, 1'b1});
                end else begin
                    foreach (shadow_q[i])
                        res.push_back('{STAT_OK, shadow_q[i], FILL_W'(shadow_q.size()),
                                        1'(i == shadow_q.size() - 1)});
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (shadow_q.size() == 0) begin
                    res.push_back('{STAT_EMPTY, '0, '0, 1'b1});
                end else begin
                    if (op == OP_POP_FRONT) popped = shadow_q.pop_front();
                    else popped = shadow_q.pop_back();
                    res.push_back('{STAT_OK, popped, FILL_W'(shadow_q.size()), 1'b1});
                end
            end
            default: begin
                // unused opcode: acknowledged, nothing changes
                res.push_back('{STAT_OK, '0, FILL_W'(shadow_q.size()), 1'b1});
            end
        endcase
    endfunction

    // predict on every accepted request, check every accepted result beat
    always @(posedge aclk) begin : scoreboard
        beat_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                fresh_beats.delete();
                deque_step(s_op, s_value, fresh_beats);
                if (cur_typed) exp_beats.push_back(cur_typed_beat);
                else foreach (fresh_beats[i]) exp_beats.push_back(fresh_beats[i]);
            end
            if (m_valid && m_ready) begin
                if (exp_beats.size() == 0) begin
                    report_mismatch("unexpected beat, data", m_data, '0);
                end else begin
                    want = exp_beats.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                    if (m_data !== want.data)
                        report_mismatch("data", m_data, want.data);
                    if (m_fill !== want.fill)
                        report_mismatch("fill", 32'(m_fill), 32'(want.fill));
                    if (m_last !== want.last)
                        report_mismatch("last", 32'(m_last), 32'(want.last));
                end
            end
        end
    end

    // mostly back-to-back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 5) begin
            quiet_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    // offer one request and hold it until the block takes it
    task automatic send_req(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val,
                            input bit typed, input beat_t typed_beat);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_op           <= op;
        s_value        <= val;
        cur_typed      = typed;
        cur_typed_beat = typed_beat;
        do @(posedge aclk); while (!s_ready);
    endtask

    // result side: random stalls, ready stretches, one long hold-off
    initial begin : receiver
        int hold_left;
        int ready_run;
        int r;
        hold_left = 0;
        ready_run = 0;
        m_ready   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (ready_run > 0) begin
                m_ready <= 1'b1;
                ready_run--;
            end else begin
                r = $urandom_range(99);
                if (r < 4) begin
                    ready_run = $urandom_range(10, 40);
                    m_ready <= 1'b1;
                end else if (r < 65) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    hold_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(5, 25);
                end
            end
        end
    end

    // request side: corner table, then random fill/drain phases
    initial begin : stimulus
        beat_t              typed_beat;
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] val;
        int                 r;
        int                 phase_left;
        bit                 filling;

        s_valid        = 1'b0;
        s_op           = OP_PUSH_FRONT;
        s_value        = '0;
        cur_typed      = 1'b0;
        cur_typed_beat = '0;
        phase_left     = 0;
        filling        = 1'b0;
        wait (aresetn === 1'b1);

        foreach (corner_tab[i]) begin
            typed_beat = '{corner_tab[i].status, '0, corner_tab[i].fill, 1'b1};
            for (int k = 0; k < corner_tab[i].reps; k++)
                send_req(corner_tab[i].op, corner_tab[i].value + k,
                         corner_tab[i].typed, typed_beat);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == HOLD_AT) long_hold_req = 1'b1;
            if (n == PAUSE_AT) begin
                // let the block run dry before going on
                @(negedge aclk);
                s_valid <= 1'b0;
                while (exp_beats.size() != 0) @(posedge aclk);
            end
            if (phase_left == 0) begin
                filling    = ~filling;
                phase_left = $urandom_range(15, 40);
            end
            phase_left--;

            r = $urandom_range(99);
            if (filling) begin
                if (r < 35)      op = OP_PUSH_FRONT;
                else if (r < 70) op = OP_PUSH_BACK;
                else if (r < 80) op = OP_LIST;
                else if (r < 88) op = OP_POP_FRONT;
                else if (r < 96) op = OP_POP_BACK;
                else             op = OP_RSVD_5 + OP_W'($urandom_range(0, 2));
            end else begin
                if (r < 10)      op = OP_PUSH_FRONT;
                else if (r < 20) op = OP_PUSH_BACK;
                else if (r < 30) op = OP_LIST;
                else if (r < 63) op = OP_POP_FRONT;
                else if (r < 96) op = OP_POP_BACK;
                else             op = OP_RSVD_5 + OP_W'($urandom_range(0, 2));
            end

            r = $urandom_range(99);
            case (r % 10)
                0:       val = 32'h7FFF_FFFF;
                1:       val = 32'h8000_0000;
                default: val = $urandom;
            endcase
            if (r < 5) val = (r < 3) ? 32'h0000_0000 : 32'hFFFF_FFFF;

            send_req(op, val, 1'b0, '0);
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // wait out the remaining beats, then a little longer
        while (exp_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
